FILE: rtl/core/lobd_pkg.sv
// ----------------------------------------------------------------------------
// lobd_pkg
// Shared types and constants of the LRA overdrive and brake driver.
// ----------------------------------------------------------------------------
package lobd_pkg;

   localparam int DUTY_W = 10;
   localparam int PULSE_W = 16;
   localparam int TIME_W = 32;
   localparam int MAG_W = 2 * DUTY_W;
   localparam logic [DUTY_W:0] DUTY_DIV = 11'd1023;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_PULSE = 2'd2,
      FUNC_PLAIN = 2'd3
   } lobd_func_type;

   typedef enum logic [1:0] {
      CSR_DUTY_MIN    = 2'd0,
      CSR_DUTY_MAX    = 2'd1,
      CSR_BOOST       = 2'd2,
      CSR_RESPONSE_MS = 2'd3
   } lobd_csr_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_min;
      logic [DUTY_W-1:0] duty_max;
      logic [DUTY_W-1:0] overdrive_boost;
      logic [DUTY_W-1:0] response_ms;
   } lobd_cfg_type;

   typedef struct packed {
      lobd_func_type      func;
      logic [DUTY_W-1:0]  intensity;
      logic [PULSE_W-1:0] pulse_ms;
      logic [MAG_W-1:0]   mag;
      logic               neg;
   } lobd_item_type;

   typedef struct packed {
      logic               request_taken;
      logic [1:0]         drive_state;
      logic               driver_enable;
      logic [DUTY_W-1:0]  pwm_duty;
   } lobd_result_type;

   function automatic logic before_ms(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

FILE: rtl/core/lobd_map.sv
// ----------------------------------------------------------------------------
// lobd_map
// Input register and intensity scaling stage: registers each request and
// multiplies its intensity by the magnitude of the configured duty span.
// ----------------------------------------------------------------------------
module lobd_map import lobd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  lobd_cfg_type       cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  lobd_func_type      in_func,
   input  logic [DUTY_W-1:0]  in_intensity,
   input  logic [PULSE_W-1:0] in_pulse_ms,
   output logic               out_valid,
   input  logic               out_ready,
   output lobd_item_type      out_item
);

   logic               s1_valid_ff;
   lobd_func_type      s1_func_ff;
   logic [DUTY_W-1:0]  s1_intensity_ff;
   logic [PULSE_W-1:0] s1_pulse_ff;
   logic               s2_valid_ff;
   lobd_item_type      s2_item_ff;
   lobd_item_type      s2_item_in;
   logic               s1_ready;
   logic               s2_ready;
   logic               span_neg;
   logic [DUTY_W-1:0]  span_mag;

   assign span_neg = cfg.duty_min > cfg.duty_max;
   assign span_mag = span_neg ? (cfg.duty_min - cfg.duty_max)
                              : (cfg.duty_max - cfg.duty_min);

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s2_item_in.func      = s1_func_ff;
      s2_item_in.intensity = s1_intensity_ff;
      s2_item_in.pulse_ms  = s1_pulse_ff;
      s2_item_in.mag       = MAG_W'(s1_intensity_ff) * MAG_W'(span_mag);
      s2_item_in.neg       = span_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
      if (s1_ready && in_valid) begin
         s1_func_ff      <= in_func;
         s1_intensity_ff <= in_intensity;
         s1_pulse_ff     <= in_pulse_ms;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_item_ff;

endmodule

FILE: rtl/core/lobd_ctrl.sv
// ----------------------------------------------------------------------------
// lobd_ctrl
// Drive state machine, millisecond clock, timers and result register.
// ----------------------------------------------------------------------------
module lobd_ctrl import lobd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  lobd_cfg_type    cfg,
   input  logic            in_valid,
   output logic            in_ready,
   input  lobd_item_type   in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output lobd_result_type out_result
);

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_OVERDRIVE = 2'd1,
      MODE_ON        = 2'd2,
      MODE_BRAKE     = 2'd3
   } mode_type;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] next_allowed_ff, next_allowed_in;
   logic [TIME_W-1:0] phase_end_ff, phase_end_in;
   logic [TIME_W-1:0] pulse_end_ff, pulse_end_in;
   logic              pulse_armed_ff, pulse_armed_in;
   mode_type          mode_ff, mode_in;
   logic [DUTY_W-1:0] target_ff, target_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              enable_ff, enable_in;
   logic              out_valid_ff;
   lobd_result_type   result_ff, result_in;

   logic [DUTY_W-1:0] quot_hi;
   logic [DUTY_W:0]   rem_sum;
   logic [DUTY_W-1:0] quot;
   logic [DUTY_W-1:0] mapped;
   logic [DUTY_W-1:0] set_target;
   logic [DUTY_W:0]   boosted;
   logic [DUTY_W-1:0] clamp_plain;
   logic [DUTY_W-1:0] clamp_boost;
   logic [TIME_W-1:0] resp_ext;
   logic              set_en;
   logic              taken;
   logic              fire;

   // Division by 1023 of a value below 2^20: one correction step suffices.
   assign quot_hi = in_item.mag[MAG_W-1:DUTY_W];
   assign rem_sum = {1'b0, in_item.mag[DUTY_W-1:0]} + {1'b0, quot_hi};
   assign quot    = quot_hi + DUTY_W'(rem_sum >= DUTY_DIV);
   assign mapped  = in_item.neg ? (cfg.duty_min - quot)
                                : (cfg.duty_min + quot);

   assign set_target  = (in_item.func == FUNC_TICK) ? cfg.duty_min : mapped;
   assign boosted     = {1'b0, set_target} + {1'b0, cfg.overdrive_boost};
   assign clamp_plain = (set_target > cfg.duty_max) ? cfg.duty_max : set_target;
   assign clamp_boost = (boosted > {1'b0, cfg.duty_max}) ? cfg.duty_max
                                                        : boosted[DUTY_W-1:0];
   assign resp_ext    = TIME_W'(cfg.response_ms);

   assign in_ready = !out_valid_ff || out_ready;

   always_comb begin
      now_in          = now_ff;
      next_allowed_in = next_allowed_ff;
      phase_end_in    = phase_end_ff;
      pulse_end_in    = pulse_end_ff;
      pulse_armed_in  = pulse_armed_ff;
      mode_in         = mode_ff;
      target_in       = target_ff;
      duty_in         = duty_ff;
      enable_in       = enable_ff;
      set_en          = 1'b0;
      taken           = 1'b0;
      fire            = 1'b0;

      case (in_item.func)
         FUNC_TICK: begin
            now_in = now_ff + TIME_W'(1);
            fire   = pulse_armed_ff && before_ms(pulse_end_ff, now_in);
            if (fire) begin
               set_en         = 1'b1;
               pulse_armed_in = 1'b0;
            end
         end
         FUNC_SET: begin
            set_en = 1'b1;
         end
         FUNC_PULSE: begin
            pulse_end_in   = now_ff + TIME_W'(in_item.pulse_ms);
            pulse_armed_in = 1'b1;
            set_en         = 1'b1;
         end
         FUNC_PLAIN: begin
            if (in_item.intensity == '0) begin
               duty_in   = '0;
               enable_in = 1'b0;
            end else begin
               duty_in   = in_item.intensity;
               enable_in = 1'b1;
            end
            taken = 1'b1;
         end
         default: begin
         end
      endcase

      if (set_en && !before_ms(now_in, next_allowed_ff)) begin
         taken           = 1'b1;
         next_allowed_in = now_in + resp_ext;
         target_in       = set_target;
         if (set_target == cfg.duty_min) begin
            if (mode_ff != MODE_OFF) begin
               duty_in      = '0;
               mode_in      = MODE_BRAKE;
               phase_end_in = now_in + resp_ext;
            end
         end else if (mode_ff == MODE_ON) begin
            duty_in      = clamp_plain;
            phase_end_in = now_in + resp_ext;
         end else begin
            if (mode_ff == MODE_OFF) begin
               enable_in = 1'b1;
            end
            duty_in      = clamp_boost;
            mode_in      = MODE_OVERDRIVE;
            phase_end_in = now_in + resp_ext;
         end
      end

      if (in_item.func == FUNC_TICK && before_ms(phase_end_in, now_in)) begin
         phase_end_in = now_in + resp_ext;
         if (mode_in == MODE_BRAKE) begin
            duty_in   = '0;
            enable_in = 1'b0;
            mode_in   = MODE_OFF;
         end else if (mode_in == MODE_OVERDRIVE) begin
            duty_in = target_in;
            mode_in = MODE_ON;
         end
      end

      result_in.pwm_duty      = duty_in;
      result_in.driver_enable = enable_in;
      result_in.drive_state   = mode_in;
      result_in.request_taken = taken;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff          <= '0;
         next_allowed_ff <= '0;
         phase_end_ff    <= '0;
         pulse_end_ff    <= '0;
         pulse_armed_ff  <= 1'b0;
         mode_ff         <= MODE_OFF;
         target_ff       <= '0;
         duty_ff         <= '0;
         enable_ff       <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else if (in_valid && in_ready) begin
         now_ff          <= now_in;
         next_allowed_ff <= next_allowed_in;
         phase_end_ff    <= phase_end_in;
         pulse_end_ff    <= pulse_end_in;
         pulse_armed_ff  <= pulse_armed_in;
         mode_ff         <= mode_in;
         target_ff       <= target_in;
         duty_ff         <= duty_in;
         enable_ff       <= enable_in;
         out_valid_ff    <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

FILE: rtl/core/lra_overdrive_brake_driver_top.sv
// ----------------------------------------------------------------------------
// lra_overdrive_brake_driver_top
// Linear resonant actuator driver with overdrive on start and braking on stop.
// ----------------------------------------------------------------------------
// Requests enter on the req_ stream: req_tuser carries the function (tick,
// set intensity, pulse, plain set), req_tdata the intensity and pulse length.
// Every request transaction yields exactly one rsp_ transaction carrying the
// PWM duty, driver enable, drive state and whether the set was taken.
// A new request can be taken every cycle unless the response side stalls;
// throughput is one transaction per cycle, set by the state-update register.
// The three stages (input, scaling and state-update registers) each have
// their own handshake, so an empty stage keeps taking requests while a
// response waits on a stalled receiver; once all stages are full, req_tready
// drops until rsp_tready returns. Registers on the csr_ port are for the
// user to write only while no transaction is in flight; the block does not
// enforce it. Synchronous reset empties the pipeline, clears the millisecond
// clock, timers and output state, puts the driver off and loads the default
// duty range 512..1023, boost 128 and response time 30 ms.
// ----------------------------------------------------------------------------
module lra_overdrive_brake_driver_top import lobd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // intensity[9:0], pulse_ms[25:10]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pwm_duty[9:0], driver_enable[10],
                                    // drive_state[12:11], request_taken[13]
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [9:0]  csr_wdata
);

   lobd_cfg_type    cfg_ff;
   logic            map_valid;
   logic            map_ready;
   lobd_item_type   map_item;
   lobd_result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_min        <= 10'd512;
         cfg_ff.duty_max        <= 10'd1023;
         cfg_ff.overdrive_boost <= 10'd128;
         cfg_ff.response_ms     <= 10'd30;
      end else if (csr_we) begin
         case (lobd_csr_type'(csr_addr))
            CSR_DUTY_MIN:    cfg_ff.duty_min        <= csr_wdata;
            CSR_DUTY_MAX:    cfg_ff.duty_max        <= csr_wdata;
            CSR_BOOST:       cfg_ff.overdrive_boost <= csr_wdata;
            CSR_RESPONSE_MS: cfg_ff.response_ms     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lobd_map u_map (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_func      (lobd_func_type'(req_tuser)),
      .in_intensity (req_tdata[9:0]),
      .in_pulse_ms  (req_tdata[25:10]),
      .out_valid    (map_valid),
      .out_ready    (map_ready),
      .out_item     (map_item)
   );

   lobd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (map_valid),
      .in_ready   (map_ready),
      .in_item    (map_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {2'b00, result.request_taken, result.drive_state,
                       result.driver_enable, result.pwm_duty};

   a_map_hold: assert property (@(posedge clock) disable iff (reset)
      map_valid && !map_ready |=> map_valid && $stable(map_item))
      else $error("Scaled item changed while the state stage was stalled.");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !map_ready)
      else $error("State stage accepted an item while the response was stalled.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Response valid directly after reset.");

endmodule

FILE: tb/sv/lra_overdrive_brake_driver_top_tb.sv
// ----------------------------------------------------------------------------
// lra_overdrive_brake_driver_top_tb
// Self-checking testbench for the LRA overdrive and brake driver.
// ----------------------------------------------------------------------------
// Requests are sent in bursts with random gaps while the response side
// stalls on its own rotating pattern. A scoreboard class predicts, for each
// accepted request, the duty, enable, drive state and taken flag, and checks
// every response against the oldest prediction. A directed sequence walks the
// drive states, then random traffic runs under several register settings.
// ----------------------------------------------------------------------------
typedef enum bit [1:0] {
   DRIVE_OFF       = 2'd0,
   DRIVE_OVERDRIVE = 2'd1,
   DRIVE_ON        = 2'd2,
   DRIVE_BRAKE     = 2'd3
} drive_mode_type;

class lobd_drive_book;
   int unsigned errors;
   lobd_pkg::lobd_cfg_type cfg;
   bit [31:0] now_ms;
   bit [31:0] next_set_ms;
   bit [31:0] phase_end_ms;
   bit [31:0] pulse_end_ms;
   bit pulse_armed;
   drive_mode_type mode;
   bit [9:0] target_duty;
   bit [9:0] duty_out;
   bit enable_out;
   lobd_pkg::lobd_result_type expected_q[$];

   function new();
      errors = 0;
      cfg.duty_min = 10'd512;
      cfg.duty_max = 10'd1023;
      cfg.overdrive_boost = 10'd128;
      cfg.response_ms = 10'd30;
      now_ms = '0;
      next_set_ms = '0;
      phase_end_ms = '0;
      pulse_end_ms = '0;
      pulse_armed = 1'b0;
      mode = DRIVE_OFF;
      target_duty = '0;
      duty_out = '0;
      enable_out = 1'b0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void write_reg(lobd_pkg::lobd_csr_type addr, bit [9:0] value);
      case (addr)
         lobd_pkg::CSR_DUTY_MIN: cfg.duty_min = value;
         lobd_pkg::CSR_DUTY_MAX: cfg.duty_max = value;
         lobd_pkg::CSR_BOOST: cfg.overdrive_boost = value;
         default: cfg.response_ms = value;
      endcase
   endfunction

   function bit earlier(bit [31:0] a, bit [31:0] b);
      bit [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   function bit [9:0] scale_intensity(bit [9:0] x);
      int span;
      int v;
      span = int'(cfg.duty_max) - int'(cfg.duty_min);
      v = int'(x) * span / 1023 + int'(cfg.duty_min);
      return v[9:0];
   endfunction

   function bit [9:0] capped(int v);
      return (v > int'(cfg.duty_max)) ? cfg.duty_max : v[9:0];
   endfunction

   function bit try_set(bit [9:0] x);
      if (earlier(now_ms, next_set_ms)) return 1'b0;
      next_set_ms = now_ms + cfg.response_ms;
      target_duty = scale_intensity(x);
      if (target_duty == cfg.duty_min) begin
         if (mode == DRIVE_OFF) return 1'b1;
         duty_out = '0;
         mode = DRIVE_BRAKE;
      end else if (mode == DRIVE_ON) begin
         duty_out = capped(int'(target_duty));
      end else begin
         if (mode == DRIVE_OFF) enable_out = 1'b1;
         duty_out = capped(int'(target_duty) + int'(cfg.overdrive_boost));
         mode = DRIVE_OVERDRIVE;
      end
      phase_end_ms = now_ms + cfg.response_ms;
      return 1'b1;
   endfunction

   function void note_request(lobd_pkg::lobd_func_type func, bit [9:0] x, bit [15:0] plen);
      lobd_pkg::lobd_result_type r;
      bit taken;
      taken = 1'b0;
      case (func)
         lobd_pkg::FUNC_TICK: begin
            now_ms = now_ms + 32'd1;
            if (pulse_armed && earlier(pulse_end_ms, now_ms)) begin
               taken = try_set(10'd0);
               pulse_armed = 1'b0;
            end
            if (earlier(phase_end_ms, now_ms)) begin
               phase_end_ms = now_ms + cfg.response_ms;
               if (mode == DRIVE_BRAKE) begin
                  duty_out = '0;
                  enable_out = 1'b0;
                  mode = DRIVE_OFF;
               end else if (mode == DRIVE_OVERDRIVE) begin
                  duty_out = target_duty;
                  mode = DRIVE_ON;
               end
            end
         end
         lobd_pkg::FUNC_SET: begin
            taken = try_set(x);
         end
         lobd_pkg::FUNC_PULSE: begin
            pulse_end_ms = now_ms + plen;
            pulse_armed = 1'b1;
            taken = try_set(x);
         end
         default: begin
            if (x == 10'd0) begin
               duty_out = '0;
               enable_out = 1'b0;
            end else begin
               enable_out = 1'b1;
               duty_out = x;
            end
            taken = 1'b1;
         end
      endcase
      r.pwm_duty = duty_out;
      r.driver_enable = enable_out;
      r.drive_state = mode;
      r.request_taken = taken;
      expected_q.push_back(r);
   endfunction

   task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
   endtask

   task check_response(logic [15:0] data);
      lobd_pkg::lobd_result_type exp;
      if (expected_q.size() == 0) begin
         report($sformatf("response %h with no request outstanding", data));
      end else begin
         exp = expected_q.pop_front();
         if (data[9:0] !== exp.pwm_duty)
            report($sformatf("pwm_duty %0d, expected %0d", data[9:0], exp.pwm_duty));
         if (data[10] !== exp.driver_enable)
            report($sformatf("driver_enable %b, expected %b", data[10], exp.driver_enable));
         if (data[12:11] !== exp.drive_state)
            report($sformatf("drive_state %0d, expected %0d", data[12:11], exp.drive_state));
         if (data[13] !== exp.request_taken)
            report($sformatf("request_taken %b, expected %b", data[13], exp.request_taken));
      end
   endtask
endclass

module lra_overdrive_brake_driver_top_tb;
   import lobd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [9:0]  csr_wdata;

   lobd_drive_book book;
   int rsp_hold = 0;
   int cycle_count = 0;

   lra_overdrive_brake_driver_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(lobd_func_type func, logic [9:0] x, logic [15:0] plen);
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, plen, x};
      req_tuser <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(func, x, plen);
   endtask

   task automatic idle_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic write_csr(lobd_csr_type addr, logic [9:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      book.write_reg(addr, value);
   endtask

   task automatic apply_settings(logic [9:0] dmin, logic [9:0] dmax, logic [9:0] boost,
                                 logic [9:0] resp);
      idle_sender(0);
      while (book.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      write_csr(CSR_DUTY_MIN, dmin);
      write_csr(CSR_DUTY_MAX, dmax);
      write_csr(CSR_BOOST, boost);
      write_csr(CSR_RESPONSE_MS, resp);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_requests(int count, bit gaps_on);
      int burst_left;
      int k;
      lobd_func_type func;
      logic [9:0] x;
      logic [15:0] plen;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            if (gaps_on) idle_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 20);
         end
         k = $urandom_range(0, 99);
         if (k < 50) func = FUNC_TICK;
         else if (k < 72) func = FUNC_SET;
         else if (k < 84) func = FUNC_PULSE;
         else func = FUNC_PLAIN;
         k = $urandom_range(0, 9);
         if (k < 2) x = 10'd0;
         else if (k == 2) x = 10'd1023;
         else x = 10'($urandom_range(0, 1023));
         if ($urandom_range(0, 3) == 0) plen = 16'($urandom_range(0, 65535));
         else plen = 16'($urandom_range(0, 40));
         send_request(func, x, plen);
         burst_left--;
      end
   endtask

   initial begin
      bit [15:0] stall_pattern;
      int pattern_age;
      stall_pattern = 16'hFFFF;
      pattern_age = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) book.check_response(rsp_tdata);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            pattern_age++;
            if (pattern_age == 64) begin
               pattern_age = 0;
               if ($urandom_range(0, 3) == 0) stall_pattern = 16'hFFFF;
               else stall_pattern = 16'($urandom()) | 16'h0001;
            end
         end
      end
   end

   initial begin
      book = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= FUNC_TICK;
      csr_we <= 1'b0;
      csr_addr <= CSR_DUTY_MIN;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk off, overdrive, on, brake and back to off with a short phase time.
      apply_settings(10'd512, 10'd1023, 10'd128, 10'd2);
      send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_SET, 10'd0, 16'd0);
      send_request(FUNC_SET, 10'd1023, 16'd0);
      repeat (2) send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_SET, 10'd1023, 16'd0);
      repeat (3) send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_SET, 10'd600, 16'd0);
      repeat (3) send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_SET, 10'd0, 16'd0);
      repeat (3) send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_PULSE, 10'd800, 16'd0);
      repeat (3) send_request(FUNC_TICK, 10'd0, 16'd0);
      send_request(FUNC_PLAIN, 10'd0, 16'd0);
      send_request(FUNC_PLAIN, 10'd1023, 16'd0);
      send_request(FUNC_PULSE, 10'd0, 16'd65535);
      send_request(FUNC_TICK, 10'd0, 16'd0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_settings(10'd0, 10'd1023, 10'd0, 10'd0);
            1: apply_settings(10'd1023, 10'd0, 10'd1023, 10'd1);
            2: apply_settings(10'd512, 10'd1023, 10'd128, 10'd30);
            3: apply_settings(10'd100, 10'd900, 10'd300, 10'd3);
            4: apply_settings(10'd0, 10'd0, 10'd1023, 10'd1023);
            5: apply_settings(10'd1023, 10'd1023, 10'd0, 10'd1000);
            default: apply_settings(10'($urandom_range(0, 1023)),
                                    10'($urandom_range(0, 1023)),
                                    10'($urandom_range(0, 1023)),
                                    10'($urandom_range(0, 12)));
         endcase
         if (phase == 3) rsp_hold = 300;
         send_random_requests(190, phase % 3 != 2);
      end

      idle_sender(0);
      while (book.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/core/lobd_pkg.sv
rtl/core/lobd_map.sv
rtl/core/lobd_ctrl.sv
rtl/core/lra_overdrive_brake_driver_top.sv
tb/sv/lra_overdrive_brake_driver_top_tb.sv
